FILE: hw/rtl/plin_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plin_pkg
// shared types and constants of the piecewise linear interpolator
// ----------------------------------------------------------------------------
package plin_pkg;

	localparam int DATA_W         = 16;
	localparam int IDX_W          = 6;
	localparam int CFG_W          = 7;
	localparam int RES_W          = 36;
	localparam int DIFF_W         = DATA_W + 1;
	localparam int PROD_W         = 2 * DIFF_W;
	localparam int QUO_W          = PROD_W + 1;
	localparam int DEF_MAX_POINTS = 64;
	localparam int DEF_QUEUE_DEPTH = 4;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	typedef struct packed {
		logic                     kind;
		logic [IDX_W-1:0]         point_index;
		logic signed [DATA_W-1:0] x_value;
		logic signed [DATA_W-1:0] y_value;
	} item_t;

endpackage

FILE: hw/rtl/plin_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plin_front
// input queue: takes items from the push side and hands them to the engine
// ----------------------------------------------------------------------------
module plin_front import plin_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  item_t item_in,
	output logic  item_avail,
	output item_t item_out,
	input  logic  item_pop
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	item_t          slot_q [QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign full       = (count_q == CW'(QUEUE_DEPTH));
	assign item_avail = (count_q != '0);
	assign item_out   = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = item_pop && item_avail;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/plin_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plin_div
// serial signed divider, one quotient bit a cycle, truncates toward zero
// ----------------------------------------------------------------------------
module plin_div import plin_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [PROD_W-1:0] dividend,
	input  logic signed [DIFF_W-1:0] divisor,
	output logic                     done,
	output logic signed [QUO_W-1:0]  quotient
);

	localparam int CNT_W = $clog2(PROD_W + 1);

	logic [PROD_W-1:0] quo_q;
	logic [DIFF_W-1:0] rem_q;
	logic [DIFF_W-1:0] dvs_q;
	logic              neg_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIFF_W:0]   shifted;
	logic [DIFF_W+1:0] trial;

	assign shifted = {rem_q, quo_q[PROD_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, dvs_q};
	assign done    = done_q;
	assign quotient = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(PROD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend[PROD_W-1] ? PROD_W'(-dividend) : dividend;
			dvs_q <= divisor[DIFF_W-1] ? DIFF_W'(-divisor) : divisor;
			neg_q <= dividend[PROD_W-1] ^ divisor[DIFF_W-1];
			rem_q <= '0;
		end else if (busy_q) begin
			// restoring step
			if (!trial[DIFF_W+1]) begin
				rem_q <= trial[DIFF_W-1:0];
				quo_q <= {quo_q[PROD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DIFF_W-1:0];
				quo_q <= {quo_q[PROD_W-2:0], 1'b0};
			end
		end
	end

endmodule

FILE: hw/rtl/plin_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plin_back
// engine: breakpoint memory, segment search, multiply, divide, result slot
// ----------------------------------------------------------------------------
module plin_back import plin_pkg::*; #(
	parameter int MAX_POINTS = DEF_MAX_POINTS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [CFG_W-1:0]        points_in_use,
	input  logic                    item_avail,
	input  item_t                   item,
	output logic                    item_pop,
	output logic                    empty,
	input  logic                    pop,
	output logic signed [RES_W-1:0] result_value,
	output logic                    status
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int NW = $clog2(MAX_POINTS + 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RD0   = 4'd1;
	localparam logic [3:0] S_RDL   = 4'd2;
	localparam logic [3:0] S_SCAN  = 4'd3;
	localparam logic [3:0] S_FETCH = 4'd4;
	localparam logic [3:0] S_F1    = 4'd5;
	localparam logic [3:0] S_F2    = 4'd6;
	localparam logic [3:0] S_MUL   = 4'd7;
	localparam logic [3:0] S_DIVGO = 4'd8;
	localparam logic [3:0] S_DIV   = 4'd9;
	localparam logic [3:0] S_OUT   = 4'd10;

	logic [2*DATA_W-1:0]      mem [MAX_POINTS];
	logic [2*DATA_W-1:0]      rdata_q;
	logic                     rd_en;
	logic [AW-1:0]            raddr;
	logic                     wr_en;

	logic [3:0]               state_q;
	logic [NW-1:0]            n_q;
	logic [NW-1:0]            n_clamp;
	logic signed [DATA_W-1:0] xq_q;
	logic signed [DATA_W-1:0] prev_q;
	logic signed [DATA_W-1:0] xa_q;
	logic signed [DATA_W-1:0] ya_q;
	logic [AW-1:0]            k_q;
	logic [AW-1:0]            a_q;
	logic signed [DIFF_W-1:0] dy_q;
	logic signed [DIFF_W-1:0] dx_q;
	logic signed [DIFF_W-1:0] dq_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [RES_W-1:0]  val_q;
	logic                     err_q;
	logic                     res_valid_q;
	logic signed [RES_W-1:0]  res_val_q;
	logic                     res_status_q;
	logic                     slot_free;

	logic signed [DATA_W-1:0] rd_x;
	logic signed [DATA_W-1:0] rd_y;
	logic                     hit;
	logic                     last_k;
	logic                     div_start;
	logic                     div_done;
	logic signed [QUO_W-1:0]  div_quo;

	assign rd_x = rdata_q[2*DATA_W-1:DATA_W];
	assign rd_y = rdata_q[DATA_W-1:0];

	// bracketing test against the previous breakpoint
	assign hit    = (prev_q <= xq_q) && (xq_q <= rd_x) && (rd_x != prev_q);
	assign last_k = (32'(k_q) == 32'(n_q) - 1);

	assign slot_free = !res_valid_q || pop;
	assign empty        = !res_valid_q;
	assign result_value = res_val_q;
	assign status       = res_status_q;

	// zero acts as one, anything above the table size as the table size
	always_comb begin
		if (points_in_use == '0) begin
			n_clamp = NW'(1);
		end else if (32'(points_in_use) > MAX_POINTS) begin
			n_clamp = NW'(MAX_POINTS);
		end else begin
			n_clamp = NW'(points_in_use);
		end
	end

	assign wr_en = (state_q == S_IDLE) && item_avail && (item.kind == KIND_LOAD) &&
		(32'(item.point_index) < MAX_POINTS);
	assign div_start = (state_q == S_DIVGO);

	always_comb begin
		rd_en    = 1'b0;
		raddr    = '0;
		item_pop = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (item_avail) begin
					item_pop = 1'b1;
					rd_en    = (item.kind == KIND_QUERY);
				end
			end
			S_RD0: begin
				if (n_q != NW'(1) && !(xq_q <= rd_x)) begin
					rd_en = 1'b1;
					raddr = AW'(n_q - 1'b1);
				end
			end
			S_RDL: begin
				if (!(rd_x <= xq_q)) begin
					rd_en = 1'b1;
					raddr = AW'(1);
				end
			end
			S_SCAN: begin
				if (!hit && !last_k) begin
					rd_en = 1'b1;
					raddr = k_q + 1'b1;
				end
			end
			S_FETCH: begin
				rd_en = 1'b1;
				raddr = a_q;
			end
			S_F1: begin
				rd_en = 1'b1;
				raddr = a_q + 1'b1;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[AW'(item.point_index)] <= {item.x_value, item.y_value};
		end
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item_avail && item.kind == KIND_QUERY) begin
						state_q <= S_RD0;
					end
				end
				S_RD0: begin
					if (n_q == NW'(1)) begin
						state_q <= S_OUT;
					end else if (xq_q <= rd_x) begin
						state_q <= S_FETCH;
					end else begin
						state_q <= S_RDL;
					end
				end
				S_RDL: begin
					state_q <= (rd_x <= xq_q) ? S_FETCH : S_SCAN;
				end
				S_SCAN: begin
					if (hit) begin
						state_q <= S_FETCH;
					end else if (last_k) begin
						state_q <= S_OUT;
					end
				end
				S_FETCH: state_q <= S_F1;
				S_F1:    state_q <= S_F2;
				S_F2: begin
					state_q <= (rd_x == xa_q) ? S_OUT : S_MUL;
				end
				S_MUL:   state_q <= S_DIVGO;
				S_DIVGO: state_q <= S_DIV;
				S_DIV: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (slot_free) begin
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				xq_q <= item.x_value;
				n_q  <= n_clamp;
			end
			S_RD0: begin
				prev_q <= rd_x;
				a_q    <= '0;
				val_q  <= RES_W'(rd_y);
				err_q  <= 1'b0;
			end
			S_RDL: begin
				a_q <= AW'(n_q - NW'(2));
				k_q <= AW'(1);
			end
			S_SCAN: begin
				prev_q <= rd_x;
				k_q    <= k_q + 1'b1;
				a_q    <= k_q - 1'b1;
				err_q  <= 1'b1;
				val_q  <= '0;
			end
			S_F1: begin
				xa_q <= rd_x;
				ya_q <= rd_y;
			end
			S_F2: begin
				dy_q  <= DIFF_W'(rd_y) - DIFF_W'(ya_q);
				dx_q  <= DIFF_W'(rd_x) - DIFF_W'(xa_q);
				dq_q  <= DIFF_W'(xq_q) - DIFF_W'(xa_q);
				err_q <= (rd_x == xa_q);
				val_q <= '0;
			end
			S_MUL: begin
				prod_s1 <= dy_q * dq_q;
			end
			S_DIV: begin
				val_q <= RES_W'(ya_q) + RES_W'(div_quo);
				err_q <= 1'b0;
			end
			S_OUT: begin
				if (slot_free) begin
					res_val_q    <= err_q ? '0 : val_q;
					res_status_q <= err_q ? STATUS_ERR : STATUS_OK;
				end
			end
			default: begin
			end
		endcase
	end

	plin_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_s1),
		.divisor  (dx_q),
		.done     (div_done),
		.quotient (div_quo)
	);

endmodule

FILE: hw/rtl/piecewise_linear_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// breakpoint table with a piecewise linear query engine
// ----------------------------------------------------------------------------
// a load item is written straight from the idle state; a query runs the table
// scan, which reads one breakpoint a cycle over the n points in use, then the
// segment fetch, the multiply and the 34-step serial divider
// one query at a time: the next item starts once the result is in
// reset: queues empty, points in use back to one, table contents undefined
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator import plin_pkg::*; #(
	parameter int MAX_POINTS  = DEF_MAX_POINTS,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// input item side
	input  logic                     push,
	output logic                     full,
	input  logic                     kind,
	input  logic [IDX_W-1:0]         point_index,
	input  logic signed [DATA_W-1:0] x_value,
	input  logic signed [DATA_W-1:0] y_value,
	// result side
	output logic                     empty,
	input  logic                     pop,
	output logic signed [RES_W-1:0]  result_value,
	output logic                     status,
	// configuration write channel
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_W-1:0]         cfg_data
);

	item_t            item_in;
	item_t            item_head;
	logic             item_avail;
	logic             item_pop;
	logic [CFG_W-1:0] points_in_use_q;

	// pack the input fields into one item
	assign item_in.kind        = kind;
	assign item_in.point_index = point_index;
	assign item_in.x_value     = x_value;
	assign item_in.y_value     = y_value;

	// the register is always writable; write it only while idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_in_use_q <= CFG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			points_in_use_q <= cfg_data;
		end
	end

	// front: short item queue that lets the push side run ahead of the engine
	plin_front #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item_in    (item_in),
		.item_avail (item_avail),
		.item_out   (item_head),
		.item_pop   (item_pop)
	);

	// back: table, segment search and arithmetic, with its own result slot
	plin_back #(
		.MAX_POINTS (MAX_POINTS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.points_in_use (points_in_use_q),
		.item_avail    (item_avail),
		.item          (item_head),
		.item_pop      (item_pop),
		.empty         (empty),
		.pop           (pop),
		.result_value  (result_value),
		.status        (status)
	);

endmodule

FILE: verif/piecewise_linear_interpolator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_tb
// self-checking bench for the breakpoint table and its interpolation engine
// ----------------------------------------------------------------------------
// loads breakpoint tables, mostly in ascending order with some repeated x,
// and fires queries at the ends, on breakpoints, inside segments and at
// random; a scoreboard keeps its own copy of the table and the point count,
// predicts each query answer and compares it with what the block pops
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator_tb;
	import plin_pkg::*;

	localparam int TABLE_SIZE = 64;
	localparam int WATCHDOG   = 5000;
	localparam int SETTLE     = 300;

	typedef struct {
		logic signed [RES_W-1:0] value;
		logic                    st;
	} answer_t;

	// scoreboard: table copy, point count and the answers still owed
	class interp_scoreboard;
		int      bx[TABLE_SIZE];
		int      by[TABLE_SIZE];
		int      points;
		answer_t owed[$];
		int      errors;
		int      queries;
		int      loads;
		int      failed_status;

		function new();
			points = 1;
			errors = 0;
			queries = 0;
			loads = 0;
			failed_status = 0;
			foreach (bx[i]) begin
				bx[i] = 0;
				by[i] = 0;
			end
		endfunction

		function int used_points();
			if (points < 1) return 1;
			if (points > TABLE_SIZE) return TABLE_SIZE;
			return points;
		endfunction

		function longint segment(int a, int b, int x);
			longint dy, dx, dq;
			dy = longint'(by[b]) - longint'(by[a]);
			dx = longint'(bx[b]) - longint'(bx[a]);
			dq = longint'(x) - longint'(bx[a]);
			return longint'(by[a]) + (dy * dq) / dx;
		endfunction

		function answer_t interpolate(int x);
			answer_t a;
			int      n;
			longint  v;
			bit      bad;
			n = used_points();
			v = 0;
			bad = 0;
			if (n == 1) begin
				v = by[0];
			end else if (x <= bx[0]) begin
				if (bx[1] == bx[0]) bad = 1;
				else v = segment(0, 1, x);
			end else if (bx[n-1] <= x) begin
				if (bx[n-1] == bx[n-2]) bad = 1;
				else v = segment(n - 2, n - 1, x);
			end else begin
				// first non-degenerate segment that brackets x
				bad = 1;
				for (int k = 1; k < n; k++) begin
					if (bx[k-1] <= x && x <= bx[k] && bx[k] != bx[k-1]) begin
						v = segment(k - 1, k, x);
						bad = 0;
						break;
					end
				end
			end
			if (bad) v = 0;
			a.value = v[RES_W-1:0];
			a.st = bad ? STATUS_ERR : STATUS_OK;
			return a;
		endfunction

		function void note_item(logic k, logic [IDX_W-1:0] idx,
				logic signed [DATA_W-1:0] x, logic signed [DATA_W-1:0] y);
			if (k == KIND_LOAD) begin
				bx[idx] = int'(x);
				by[idx] = int'(y);
				loads++;
			end else begin
				owed.push_back(interpolate(int'(x)));
				queries++;
			end
		endfunction

		function void check_result(logic signed [RES_W-1:0] v, logic st);
			answer_t e;
			if (owed.size() == 0) begin
				$display("%0t: unexpected result value %0d status %0b", $time, v, st);
				errors++;
				return;
			end
			e = owed.pop_front();
			if (st == STATUS_ERR) failed_status++;
			if (v !== e.value) begin
				$display("%0t: result_value mismatch, expected %0d actual %0d",
					$time, e.value, v);
				errors++;
			end
			if (st !== e.st) begin
				$display("%0t: status mismatch, expected %0b actual %0b", $time, e.st, st);
				errors++;
			end
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     push;
	logic                     full;
	logic                     kind;
	logic [IDX_W-1:0]         point_index;
	logic signed [DATA_W-1:0] x_value;
	logic signed [DATA_W-1:0] y_value;
	logic                     empty;
	logic                     pop;
	logic signed [RES_W-1:0]  result_value;
	logic                     status;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_W-1:0]         cfg_data;

	interp_scoreboard sb;
	bit               hold_request;
	int               idle_cycles;
	int               settings_done;

	piecewise_linear_interpolator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.kind         (kind),
		.point_index  (point_index),
		.x_value      (x_value),
		.y_value      (y_value),
		.empty        (empty),
		.pop          (pop),
		.result_value (result_value),
		.status       (status),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// gap length: mostly none or short, now and then long
	function int gap_length();
		int r;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(3, 1);
		return $urandom_range(60, 15);
	endfunction

	// accepted traffic goes to the scoreboard at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) sb.note_item(kind, point_index, x_value, y_value);
			if (pop && !empty) sb.check_result(result_value, status);
			if (cfg_valid && cfg_ready) sb.points = int'(cfg_data);
		end
	end

	// watchdog on cycles with no accepted item on any channel
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// result side: random pops, with one long hold-off on request
	initial begin
		int g;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				pop = 1'b0;
				repeat (500) @(negedge clk);
				hold_request = 0;
			end else begin
				g = gap_length();
				if (g > 0) begin
					pop = 1'b0;
					repeat (g - 1) @(negedge clk);
				end else begin
					pop = 1'b1;
				end
			end
		end
	end

	task automatic send_item(logic k, logic [IDX_W-1:0] idx,
			logic signed [DATA_W-1:0] x, logic signed [DATA_W-1:0] y);
		int g;
		g = gap_length();
		if (g > 0) begin
			push = 1'b0;
			repeat (g) @(negedge clk);
		end
		kind = k;
		point_index = idx;
		x_value = x;
		y_value = y;
		push = 1'b1;
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	task automatic load_point(int idx, int x, int y);
		send_item(KIND_LOAD, idx[IDX_W-1:0], x[DATA_W-1:0], y[DATA_W-1:0]);
	endtask

	task automatic query_at(int x);
		send_item(KIND_QUERY, IDX_W'($urandom), x[DATA_W-1:0], DATA_W'($urandom));
	endtask

	// drain everything, let the engine settle, then write the point count
	task automatic set_points(int n);
		push = 1'b0;
		while (sb.owed.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_data = n[CFG_W-1:0];
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		settings_done++;
	endtask

	// whole table in ascending x, with occasional repeats and a few spoilers
	task automatic load_table();
		int x;
		int step;
		x = $urandom_range(1, 0) ? -32768 : -32768 + $urandom_range(12000);
		for (int i = 0; i < TABLE_SIZE; i++) begin
			if ($urandom_range(19) == 0) load_point(i, $urandom, $urandom);
			else load_point(i, x, $urandom);
			step = ($urandom_range(9) == 0) ? 0 : $urandom_range(1100, 1);
			x = (x + step > 32767) ? 32767 : x + step;
		end
	endtask

	// query coordinate aimed at the table in use
	function int pick_x();
		int n;
		int lo;
		int hi;
		int k;
		n = sb.used_points();
		lo = sb.bx[0];
		hi = sb.bx[n-1];
		k = $urandom_range(n - 1);
		case ($urandom_range(5))
			0: return $urandom_range(65535) - 32768;
			1: return sb.bx[k];
			2: return ($urandom_range(1) ? lo : hi) + $urandom_range(4) - 2;
			3: return $urandom_range(1) ? -32768 : 32767;
			default: begin
				if (lo < hi) return lo + $urandom_range(hi - lo);
				return $urandom_range(65535) - 32768;
			end
		endcase
	endfunction

	initial begin
		int settings[12] = '{1, 0, 2, 3, 64, 127, 8, 65, 33, 64, 5, 100};
		sb = new();
		hold_request = 0;
		settings_done = 0;
		idle_cycles = 0;
		push = 1'b0;
		kind = KIND_LOAD;
		point_index = '0;
		x_value = '0;
		y_value = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: a single point in use gives the first y
		load_point(0, -32768, 32767);
		query_at(32767);
		query_at(-32768);
		// four points with a repeated x in the middle
		load_point(1, -100, -32768);
		load_point(2, -100, 5);
		load_point(3, 32767, -32768);
		load_point(63, 32767, 32767);
		set_points(4);
		query_at(-32768);
		query_at(32767);
		query_at(-100);
		query_at(0);
		query_at(-5000);
		// zero-width first segment
		load_point(1, -32768, -7);
		query_at(-32768);
		query_at(-40);
		// zero-width last segment
		load_point(3, -100, 9);
		query_at(100);
		query_at(-100);

		// random phases over a run of point counts, extremes included
		foreach (settings[p]) begin
			load_table();
			set_points(settings[p]);
			if (p == 2) hold_request = 1;
			repeat (85) begin
				if ($urandom_range(3) == 0)
					load_point($urandom_range(TABLE_SIZE - 1),
						$urandom_range(1) ? $urandom : pick_x(), $urandom);
				else
					query_at(pick_x());
			end
		end
		push = 1'b0;

		while (sb.owed.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);

		$display("covered %0d queries and %0d loads over %0d point-count settings",
			sb.queries, sb.loads, settings_done);
		$display("%0d answers came back with the error status", sb.failed_status);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/plin_pkg.sv
hw/rtl/plin_front.sv
hw/rtl/plin_div.sv
hw/rtl/plin_back.sv
hw/rtl/piecewise_linear_interpolator.sv
verif/piecewise_linear_interpolator_tb.sv
